### hdl/jsed_pkg.sv
package jsed_pkg;

    localparam int CP_W  = 21;
    localparam int CNT_W = 3;

    localparam logic [CP_W-1:0] MAX_CP_RESET = 21'h10FFFF;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_HEX2   = 3'd1,
        MODE_USTART = 3'd2,
        MODE_HEX4   = 3'd3,
        MODE_BRACE  = 3'd4,
        MODE_OCTAL  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_HEX  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_ILLEGAL  = 2'd3
    } status_t;

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] code_point;
        status_t         status;
        logic            consumed;
    } result_t;

    // source bytes with a meaning of their own
    localparam logic [7:0] CHAR_B      = 8'h62;
    localparam logic [7:0] CHAR_F      = 8'h66;
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_T      = 8'h74;
    localparam logic [7:0] CHAR_V      = 8'h76;
    localparam logic [7:0] CHAR_X      = 8'h78;
    localparam logic [7:0] CHAR_U      = 8'h75;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_SEVEN  = 8'h37;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_UC_A   = 8'h41;
    localparam logic [7:0] CHAR_UC_F   = 8'h46;
    localparam logic [7:0] CHAR_LC_A   = 8'h61;
    localparam logic [7:0] CHAR_LC_F   = 8'h66;

    localparam logic [CP_W-1:0] CP_BS = 21'd8;
    localparam logic [CP_W-1:0] CP_FF = 21'd12;
    localparam logic [CP_W-1:0] CP_LF = 21'd10;
    localparam logic [CP_W-1:0] CP_CR = 21'd13;
    localparam logic [CP_W-1:0] CP_HT = 21'd9;
    localparam logic [CP_W-1:0] CP_VT = 21'd11;

    localparam logic [CP_W-1:0] OCT_LIMIT  = 21'd32;
    localparam logic [CNT_W-1:0] HEX2_LEN  = 3'd2;
    localparam logic [CNT_W-1:0] HEX4_LEN  = 3'd4;
    localparam logic [CNT_W-1:0] OCT_LEN   = 3'd3;

    // {is_hex, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= CHAR_ZERO && b <= CHAR_NINE)
            r = {1'b1, 4'(b - CHAR_ZERO)};
        else if (b >= CHAR_UC_A && b <= CHAR_UC_F)
            r = {1'b1, 4'(b - CHAR_UC_A + 8'd10)};
        else if (b >= CHAR_LC_A && b <= CHAR_LC_F)
            r = {1'b1, 4'(b - CHAR_LC_A + 8'd10)};
        return r;
    endfunction

endpackage

### hdl/js_string_escape_decoder_core.sv
// channel   direction  signals                          contents
// s_axis    in         s_tvalid s_tready s_tdata[7:0]   source byte
// m_axis    out        m_tvalid m_tready m_tdata[23:0]  code point, consumed
//                      m_tuser[1:0]                     status
// cfg       in         cfg_valid cfg_ready cfg_data     max code point
//
// one byte per cycle unless the output stalls: a byte is held in the input register,
// is decoded against the escape state and its result, if any, lands in the output
// register; reset clears the escape state to idle and both stage valids and sets
// the max code point to 10FFFF; a stalled output holds the decoder; input keeps
// flowing while the output register drains in the same cycle
module js_string_escape_decoder_core
    import jsed_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [21] consumed, [23:22] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [20:0] cfg_data
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_free;
    logic       fire;
    result_t    res;

    assign fire      = in_valid && out_free;
    assign cfg_ready = 1'b1;

    jsed_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .fire     (fire),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    jsed_decode u_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .in_byte   (in_byte),
        .res       (res)
    );

    jsed_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire && res.valid),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### hdl/jsed_in_stage.sv
module jsed_in_stage
    import jsed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       fire,
    output logic       in_valid,
    output logic [7:0] in_byte
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign s_tready = !valid_reg || fire;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (fire)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            byte_reg <= s_tdata;
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

### hdl/jsed_decode.sv
module jsed_decode
    import jsed_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    input  logic [CP_W-1:0] cfg_data,
    input  logic            fire,
    input  logic [7:0]      in_byte,
    output result_t         res
);

    mode_t            mode_reg, mode_next;
    logic [CP_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CP_W-1:0]  max_cp_reg;

    logic [4:0]       hex;
    logic             is_hex;
    logic [3:0]       hval;
    logic             is_oct;
    logic [2:0]       oval;
    logic [CNT_W-1:0] cnt_inc;
    logic [CP_W-1:0]  acc_hex;
    logic [CP_W-1:0]  acc_oct;
    logic [CP_W+3:0]  brace_next;

    assign hex        = hex_digit(in_byte);
    assign is_hex     = hex[4];
    assign hval       = hex[3:0];
    assign is_oct     = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_SEVEN);
    assign oval       = in_byte[2:0];
    assign cnt_inc    = cnt_reg + 3'd1;
    assign acc_hex    = {acc_reg[CP_W-5:0], hval};
    assign acc_oct    = {acc_reg[CP_W-4:0], oval};
    assign brace_next = {acc_reg, hval};

    always_comb
    begin
        mode_next      = mode_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        res.valid      = 1'b0;
        res.code_point = '0;
        res.status     = ST_OK;
        res.consumed   = 1'b1;

        case (mode_reg)
            MODE_HEX2, MODE_HEX4:
            begin
                if (!is_hex)
                begin
                    res.valid  = 1'b1;
                    res.status = ST_BAD_HEX;
                end
                else if (cnt_inc >= ((mode_reg == MODE_HEX2) ? HEX2_LEN : HEX4_LEN))
                begin
                    res.valid      = 1'b1;
                    res.code_point = acc_hex;
                end
                else
                begin
                    acc_next = acc_hex;
                    cnt_next = cnt_inc;
                end
            end
            MODE_USTART:
            begin
                if (in_byte == CHAR_LBRACE)
                begin
                    mode_next = MODE_BRACE;
                    acc_next  = '0;
                end
                else if (!is_hex)
                begin
                    res.valid  = 1'b1;
                    res.status = ST_BAD_HEX;
                end
                else
                begin
                    mode_next = MODE_HEX4;
                    acc_next  = CP_W'(hval);
                    cnt_next  = 3'd1;
                end
            end
            MODE_BRACE:
            begin
                if (in_byte == CHAR_RBRACE)
                begin
                    res.valid      = 1'b1;
                    res.code_point = acc_reg;
                end
                else if (!is_hex)
                begin
                    res.valid  = 1'b1;
                    res.status = ST_BAD_HEX;
                end
                else if (brace_next > {4'd0, max_cp_reg})
                begin
                    res.valid  = 1'b1;
                    res.status = ST_OVERFLOW;
                end
                else
                    acc_next = brace_next[CP_W-1:0];
            end
            MODE_OCTAL:
            begin
                if (!is_oct)
                begin
                    // the terminating byte is left for the caller
                    res.valid      = 1'b1;
                    res.code_point = acc_reg;
                    res.consumed   = 1'b0;
                end
                else if (cnt_inc >= OCT_LEN || acc_oct >= OCT_LIMIT)
                begin
                    res.valid      = 1'b1;
                    res.code_point = acc_oct;
                end
                else
                begin
                    acc_next = acc_oct;
                    cnt_next = cnt_inc;
                end
            end
            default:
            begin
                // idle: byte is the escape letter
                case (in_byte)
                    CHAR_B: begin res.valid = 1'b1; res.code_point = CP_BS; end
                    CHAR_F: begin res.valid = 1'b1; res.code_point = CP_FF; end
                    CHAR_N: begin res.valid = 1'b1; res.code_point = CP_LF; end
                    CHAR_R: begin res.valid = 1'b1; res.code_point = CP_CR; end
                    CHAR_T: begin res.valid = 1'b1; res.code_point = CP_HT; end
                    CHAR_V: begin res.valid = 1'b1; res.code_point = CP_VT; end
                    CHAR_X:
                    begin
                        mode_next = MODE_HEX2;
                        acc_next  = '0;
                        cnt_next  = '0;
                    end
                    CHAR_U:
                    begin
                        mode_next = MODE_USTART;
                        acc_next  = '0;
                        cnt_next  = '0;
                    end
                    default:
                    begin
                        if (is_oct)
                        begin
                            mode_next = MODE_OCTAL;
                            acc_next  = CP_W'(oval);
                            cnt_next  = 3'd1;
                        end
                        else
                        begin
                            res.valid  = 1'b1;
                            res.status = ST_ILLEGAL;
                        end
                    end
                endcase
            end
        endcase

        if (res.valid)
        begin
            mode_next = MODE_IDLE;
            acc_next  = '0;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_cp_reg <= MAX_CP_RESET;
        else if (cfg_valid)
            max_cp_reg <= cfg_data;
    end

    a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.valid |=> mode_reg == MODE_IDLE && acc_reg == '0 && cnt_reg == '0)
        else $error("decoder did not return to idle after a result");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(mode_reg) && $stable(acc_reg) && $stable(cnt_reg))
        else $error("decode state moved without a transaction");

    a_octal_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_OCTAL |-> acc_reg < OCT_LIMIT && cnt_reg >= 3'd1 && cnt_reg < OCT_LEN)
        else $error("octal accumulator out of range");

    a_hex_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_HEX2 || cnt_reg < HEX2_LEN) &&
        (mode_reg != MODE_HEX4 || (cnt_reg >= 3'd1 && cnt_reg < HEX4_LEN)))
        else $error("hex digit count out of range");

endmodule

### hdl/jsed_out_stage.sv
module jsed_out_stage
    import jsed_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  result_t      res,
    output logic         out_free,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,
    output logic [1:0]   m_tuser
);

    logic            valid_reg, valid_next;
    logic [CP_W-1:0] cp_reg;
    status_t         status_reg;
    logic            consumed_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg       <= res.code_point;
            status_reg   <= res.status;
            consumed_reg <= res.consumed;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, consumed_reg, cp_reg};
    assign m_tuser  = status_reg;

endmodule
